FILE: rtl/core/adcp_pkg.sv
// Shared constants, codes and types of the audio DSP command port.
package adcp_pkg;

   // Default depth of the DSP reply queue
   localparam int REPLY_DEPTH_DEFAULT = 4;

   // Request type codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_EVENT = 2'd2;

   // Port offsets from the card base
   localparam logic [3:0] PORT_MIXER_INDEX = 4'h4;
   localparam logic [3:0] PORT_MIXER_DATA  = 4'h5;
   localparam logic [3:0] PORT_RESET       = 4'h6;
   localparam logic [3:0] PORT_READ_DATA   = 4'hA;
   localparam logic [3:0] PORT_COMMAND     = 4'hC;
   localparam logic [3:0] PORT_READ_STATUS = 4'hE;
   localparam logic [3:0] PORT_IRQ_ACK     = 4'hF;

   // DSP commands and reply bytes
   localparam logic [7:0] CMD_NONE     = 8'h00;
   localparam logic [7:0] CMD_VERSION  = 8'hE1;
   localparam logic [7:0] CMD_RATE     = 8'h41;
   localparam logic [7:0] CMD_START16  = 8'hB6;
   localparam logic [7:0] CMD_STOP16   = 8'hD9;
   localparam logic [7:0] RESET_ACK    = 8'hAA;
   localparam logic [7:0] DSP_MAJOR    = 8'h04;
   localparam logic [7:0] STATUS_READY = 8'h80;
   localparam int         MODE_STEREO_BIT = 5;

   // Mixer register indices and their slots
   localparam logic [7:0] MIX_IDX_VOL0 = 8'h30;
   localparam logic [7:0] MIX_IDX_VOL1 = 8'h31;
   localparam logic [7:0] MIX_IDX_VOL2 = 8'h32;
   localparam logic [7:0] MIX_IDX_VOL3 = 8'h33;
   localparam logic [7:0] MIX_IDX_IRQ  = 8'h80;
   localparam logic [7:0] MIX_IDX_DMA  = 8'h81;
   localparam int         MIXER_REGS   = 6;
   localparam logic [2:0] MIX_SLOT_VOL0 = 3'd0;
   localparam logic [2:0] MIX_SLOT_VOL1 = 3'd1;
   localparam logic [2:0] MIX_SLOT_VOL2 = 3'd2;
   localparam logic [2:0] MIX_SLOT_VOL3 = 3'd3;
   localparam logic [2:0] MIX_SLOT_IRQ  = 3'd4;
   localparam logic [2:0] MIX_SLOT_DMA  = 3'd5;
   localparam logic [2:0] MIX_SLOT_NONE = 3'd7;

   // One bus access or DMA event
   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] port_offset;
      logic [7:0] write_data;
   } item_type;

   // One response
   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq_pending;
      logic        playing;
      logic [15:0] sample_rate;
      logic        stereo;
      logic [15:0] block_count;
      logic [7:0]  irq_select;
      logic [7:0]  dma_select;
   } rsp_type;

   // Reply queue control for one request
   typedef struct packed {
      logic       clear;
      logic       push0;
      logic       push1;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       pop;
   } fifo_ctl_type;

   // Reply queue status
   typedef struct packed {
      logic [7:0] head;
      logic       nonempty;
   } fifo_status_type;

endpackage

FILE: rtl/core/audio_dsp_command_port.sv
// Top level of the audio DSP command port: request register, DSP state, response register.
// Each request is one port write or read, or a DMA block-done event, and gives one response
// carrying the read byte and the current playback, rate, mode, count, interrupt and mixer
// select state. One request is taken every clock cycle while the response is not stalled; a
// response reaches the response ports through the request register, then decode and state
// update into the response register, and a stalled response holds only the request
// register, so one more request is taken behind it. A write of 1 then 0 to the reset port
// clears the parser, the reply queue of REPLY_DEPTH bytes and playback, and queues 0xAA;
// csr_write_enable sets the minor version.
module audio_dsp_command_port #(
   parameter int REPLY_DEPTH = adcp_pkg::REPLY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_port_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_pending,
   output logic        rsp_playing,
   output logic [15:0] rsp_sample_rate,
   output logic        rsp_stereo,
   output logic [15:0] rsp_block_count,
   output logic [7:0]  rsp_irq_select,
   output logic [7:0]  rsp_dma_select,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic               in_valid_ff, in_valid_in;
   adcp_pkg::item_type in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   adcp_pkg::rsp_type  rsp_ff, rsp_in;
   logic               advance;
   logic               req_take;

   // Advance a request when the response register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   adcp_dsp #(
      .REPLY_DEPTH(REPLY_DEPTH)
   ) u_dsp (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .item            (in_item_ff),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp             (rsp_in)
   );

   // Compute the valid flags of both registers
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.req_type    <= req_type;
         in_item_ff.port_offset <= req_port_offset;
         in_item_ff.write_data  <= req_write_data;
      end
   end

   // Capture the response
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_irq_pending = rsp_ff.irq_pending;
   assign rsp_playing     = rsp_ff.playing;
   assign rsp_sample_rate = rsp_ff.sample_rate;
   assign rsp_stereo      = rsp_ff.stereo;
   assign rsp_block_count = rsp_ff.block_count;
   assign rsp_irq_select  = rsp_ff.irq_select;
   assign rsp_dma_select  = rsp_ff.dma_select;

endmodule

FILE: rtl/core/adcp_reply_fifo.sv
// DSP reply queue: shift register read at its head, up to two pushes per request.
module adcp_reply_fifo #(
   parameter int REPLY_DEPTH = adcp_pkg::REPLY_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  adcp_pkg::fifo_ctl_type   ctl,
   output adcp_pkg::fifo_status_type status
);

   localparam int CW = $clog2(REPLY_DEPTH + 1);
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(REPLY_DEPTH);

   logic [7:0]    q_ff [REPLY_DEPTH];
   logic [7:0]    q_in [REPLY_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW:0]   base;
   logic [CW:0]   sum;

   // Show the oldest byte, zero when empty
   always_comb begin
      status.nonempty = (count_ff != '0);
      status.head     = status.nonempty ? q_ff[0] : 8'h00;
   end

   // Shift on pop, write pushes behind the last queued byte, drop when full
   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      base     = ctl.clear ? '0 : {1'b0, count_ff};
      sum      = base + (CW + 1)'(ctl.push0) + (CW + 1)'(ctl.push1);
      if (ctl.pop && (count_ff != '0)) begin
         for (int i = 0; i < REPLY_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         count_in = count_ff - CW'(1);
      end else begin
         for (int i = 0; i < REPLY_DEPTH; i++) begin
            if (ctl.push0 && ((CW + 1)'(i) == base)) begin
               q_in[i] = ctl.byte0;
            end
            if (ctl.push1 && ((CW + 1)'(i) == base + (CW + 1)'(1))) begin
               q_in[i] = ctl.byte1;
            end
         end
         count_in = (sum > DEPTH_W) ? DEPTH_W[CW-1:0] : sum[CW-1:0];
      end
   end

   // Hold the queue bytes
   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // Hold the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/adcp_dsp.sv
// DSP state: command parser, mixer, playback and interrupt, one request per enable.
module adcp_dsp #(
   parameter int REPLY_DEPTH = adcp_pkg::REPLY_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  adcp_pkg::item_type item,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   output adcp_pkg::rsp_type  rsp
);

   logic        reset_line_ff, reset_line_in;
   logic [7:0]  pending_ff, pending_in;
   logic [1:0]  args_ff, args_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  mixer_index_ff, mixer_index_in;
   logic [7:0]  mixer_ff [adcp_pkg::MIXER_REGS];
   logic [7:0]  mixer_in [adcp_pkg::MIXER_REGS];
   logic [15:0] rate_ff, rate_in;
   logic        stereo_ff, stereo_in;
   logic [15:0] count_ff, count_in;
   logic        play_ff, play_in;
   logic        irq_ff, irq_in;
   logic [7:0]  minor_ff;
   logic [7:0]  read_data;
   logic [2:0]  slot;

   adcp_pkg::fifo_ctl_type    fctl;
   adcp_pkg::fifo_status_type fstat;

   // Map a mixer index to its register slot
   function automatic logic [2:0] mixer_slot(input logic [7:0] idx);
      logic [2:0] s;
      unique case (idx)
         adcp_pkg::MIX_IDX_VOL0: s = adcp_pkg::MIX_SLOT_VOL0;
         adcp_pkg::MIX_IDX_VOL1: s = adcp_pkg::MIX_SLOT_VOL1;
         adcp_pkg::MIX_IDX_VOL2: s = adcp_pkg::MIX_SLOT_VOL2;
         adcp_pkg::MIX_IDX_VOL3: s = adcp_pkg::MIX_SLOT_VOL3;
         adcp_pkg::MIX_IDX_IRQ:  s = adcp_pkg::MIX_SLOT_IRQ;
         adcp_pkg::MIX_IDX_DMA:  s = adcp_pkg::MIX_SLOT_DMA;
         default:                s = adcp_pkg::MIX_SLOT_NONE;
      endcase
      return s;
   endfunction

   adcp_reply_fifo #(
      .REPLY_DEPTH(REPLY_DEPTH)
   ) u_reply_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fctl),
      .status(fstat)
   );

   assign slot = mixer_slot(mixer_index_ff);

   // Decode the request and work out the next state
   always_comb begin
      reset_line_in  = reset_line_ff;
      pending_in     = pending_ff;
      args_in        = args_ff;
      hold_in        = hold_ff;
      mixer_index_in = mixer_index_ff;
      mixer_in       = mixer_ff;
      rate_in        = rate_ff;
      stereo_in      = stereo_ff;
      count_in       = count_ff;
      play_in        = play_ff;
      irq_in         = irq_ff;
      fctl           = '0;
      read_data      = 8'h00;
      if (enable) begin
         unique case (item.req_type)
            adcp_pkg::REQ_WRITE: begin
               unique case (item.port_offset)
                  adcp_pkg::PORT_MIXER_INDEX: begin
                     mixer_index_in = item.write_data;
                  end
                  adcp_pkg::PORT_MIXER_DATA: begin
                     if (slot != adcp_pkg::MIX_SLOT_NONE) begin
                        mixer_in[slot] = item.write_data;
                     end
                  end
                  adcp_pkg::PORT_RESET: begin
                     // falling reset line: clear parser, queue and playback
                     if (reset_line_ff && !item.write_data[0]) begin
                        pending_in = adcp_pkg::CMD_NONE;
                        args_in    = 2'd0;
                        hold_in    = 8'h00;
                        play_in    = 1'b0;
                        fctl.clear = 1'b1;
                        fctl.push0 = 1'b1;
                        fctl.byte0 = adcp_pkg::RESET_ACK;
                     end
                     reset_line_in = item.write_data[0];
                  end
                  adcp_pkg::PORT_COMMAND: begin
                     if (args_ff == 2'd0) begin
                        // new command byte
                        priority if (item.write_data == adcp_pkg::CMD_VERSION) begin
                           fctl.push0 = 1'b1;
                           fctl.byte0 = adcp_pkg::DSP_MAJOR;
                           fctl.push1 = 1'b1;
                           fctl.byte1 = minor_ff;
                        end else if (item.write_data == adcp_pkg::CMD_RATE) begin
                           pending_in = adcp_pkg::CMD_RATE;
                           args_in    = 2'd2;
                        end else if (item.write_data == adcp_pkg::CMD_START16) begin
                           pending_in = adcp_pkg::CMD_START16;
                           args_in    = 2'd3;
                        end else if (item.write_data == adcp_pkg::CMD_STOP16) begin
                           play_in = 1'b0;
                        end else begin
                           // drop unknown commands, parser stays idle
                        end
                     end else begin
                        // argument byte of the pending command
                        if (pending_ff == adcp_pkg::CMD_RATE) begin
                           if (args_ff == 2'd2) begin
                              hold_in = item.write_data;
                           end else begin
                              rate_in = {hold_ff, item.write_data};
                           end
                        end else if (pending_ff == adcp_pkg::CMD_START16) begin
                           if (args_ff == 2'd3) begin
                              stereo_in = item.write_data[adcp_pkg::MODE_STEREO_BIT];
                           end else if (args_ff == 2'd2) begin
                              hold_in = item.write_data;
                           end else begin
                              count_in = {item.write_data, hold_ff};
                              play_in  = 1'b1;
                           end
                        end
                        args_in = args_ff - 2'd1;
                        if (args_ff == 2'd1) begin
                           pending_in = adcp_pkg::CMD_NONE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            adcp_pkg::REQ_READ: begin
               unique case (item.port_offset)
                  adcp_pkg::PORT_MIXER_DATA: begin
                     if (slot != adcp_pkg::MIX_SLOT_NONE) begin
                        read_data = mixer_ff[slot];
                     end
                  end
                  adcp_pkg::PORT_READ_DATA: begin
                     read_data = fstat.head;
                     fctl.pop  = 1'b1;
                  end
                  adcp_pkg::PORT_READ_STATUS: begin
                     read_data = fstat.nonempty ? adcp_pkg::STATUS_READY : 8'h00;
                  end
                  adcp_pkg::PORT_IRQ_ACK: begin
                     irq_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            adcp_pkg::REQ_EVENT: begin
               if (play_ff) begin
                  irq_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Form the response from the state after this request
   always_comb begin
      rsp.read_data   = read_data;
      rsp.irq_pending = irq_in;
      rsp.playing     = play_in;
      rsp.sample_rate = rate_in;
      rsp.stereo      = stereo_in;
      rsp.block_count = count_in;
      rsp.irq_select  = mixer_in[adcp_pkg::MIX_SLOT_IRQ];
      rsp.dma_select  = mixer_in[adcp_pkg::MIX_SLOT_DMA];
   end

   // Hold the DSP state
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_line_ff  <= 1'b0;
         pending_ff     <= adcp_pkg::CMD_NONE;
         args_ff        <= 2'd0;
         hold_ff        <= 8'h00;
         mixer_index_ff <= 8'h00;
         for (int i = 0; i < adcp_pkg::MIXER_REGS; i++) begin
            mixer_ff[i] <= 8'h00;
         end
         rate_ff        <= 16'h0000;
         stereo_ff      <= 1'b0;
         count_ff       <= 16'h0000;
         play_ff        <= 1'b0;
         irq_ff         <= 1'b0;
      end else begin
         reset_line_ff  <= reset_line_in;
         pending_ff     <= pending_in;
         args_ff        <= args_in;
         hold_ff        <= hold_in;
         mixer_index_ff <= mixer_index_in;
         mixer_ff       <= mixer_in;
         rate_ff        <= rate_in;
         stereo_ff      <= stereo_in;
         count_ff       <= count_in;
         play_ff        <= play_in;
         irq_ff         <= irq_in;
      end
   end

   // Hold the minor version register
   always_ff @(posedge clock) begin
      if (reset) begin
         minor_ff <= 8'h05;
      end else if (csr_write_enable) begin
         minor_ff <= csr_write_data;
      end
   end

endmodule

FILE: rtl/core/adcp_checker.sv
// Port checker of the audio DSP command port and its bind to the top level.
module adcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_type,
   input logic [3:0]  req_port_offset,
   input logic [7:0]  req_write_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_irq_pending,
   input logic        rsp_playing,
   input logic [15:0] rsp_sample_rate,
   input logic        rsp_stereo,
   input logic [15:0] rsp_block_count,
   input logic [7:0]  rsp_irq_select,
   input logic [7:0]  rsp_dma_select
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       last_valid_ff, last_irq_ff, last_play_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Count requests accepted and not yet answered
   always_comb begin
      outstanding_in = outstanding_ff + 2'(req_take) - 2'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
         last_valid_ff  <= 1'b0;
         last_irq_ff    <= 1'b0;
         last_play_ff   <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
         if (rsp_take) begin
            last_valid_ff <= 1'b1;
            last_irq_ff   <= rsp_irq_pending;
            last_play_ff  <= rsp_playing;
         end
      end
   end

   // A waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type)
         && $stable(req_port_offset) && $stable(req_write_data))
      else $error("request changed while waiting");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_irq_pending) && $stable(rsp_playing)
         && $stable(rsp_sample_rate) && $stable(rsp_block_count)
         && $stable(rsp_stereo) && $stable(rsp_irq_select)
         && $stable(rsp_dma_select))
      else $error("response changed while stalled");

   // An empty response side never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response waiting");

   // No response without an accepted request, at most two in flight
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != 2'd0) && (outstanding_ff != 2'd3))
      else $error("response without a matching request");

   // The interrupt only rises while a transfer was playing
   a_irq_needs_play: assert property (@(posedge clock) disable iff (reset)
      rsp_take && last_valid_ff && rsp_irq_pending && !last_irq_ff |-> last_play_ff)
      else $error("interrupt raised while not playing");

endmodule

bind audio_dsp_command_port adcp_checker u_adcp_checker (.*);
